@@ hw/rtl/fr_pkg.sv @@
// fr_pkg: shared types and constants for the fraction reducer.
// Used by fr_front, fr_queue, fr_back and fraction_reducer_core.
package fr_pkg;

    localparam int MAG_W = 32;
    localparam int DEN_W = 31;
    localparam int CNT_W = 5;

    localparam logic [CNT_W-1:0] DIV_LAST = 5'd31;

    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ZERO_NUM,
        KIND_ZERO_DEN
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD,
        ST_SCALE,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic               neg;
        logic [MAG_W-1:0]   mag_n;
        logic [MAG_W-1:0]   mag_d;
    } t_item;

endpackage

@@ hw/rtl/fraction_reducer_core.sv @@
// fraction_reducer_core: reduces a signed fraction to lowest terms.
// Zero numerator or denominator goes straight to the result; otherwise binary GCD steps
// run until both operands match, then a scale step, then 32 divide steps.
// Throughput: one word per back-end run; the queue takes new words meanwhile.
// Reset: i_rst_n synchronous active low; clears queue, FSM and output valid.
// Depends on fr_pkg, fr_front, fr_queue, fr_back.
module fraction_reducer_core
    import fr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           s_axis_tvalid,
    output logic           s_axis_tready,
    input  logic [63:0]    s_axis_tdata,   // [31:0] numerator_in, [63:32] denominator_in
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [63:0]    m_axis_tdata,   // [31:0] numerator_out, [62:32] denominator_out
    output logic           m_axis_tuser    // [0] zero_denominator
);

    t_item              w_push_item;
    t_item              w_head_item;
    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_empty;
    logic [MAG_W-1:0]   w_num;
    logic [DEN_W-1:0]   w_den;

    fr_front u_front (
        .i_valid (s_axis_tvalid),
        .i_num   (s_axis_tdata[31:0]),
        .i_den   (s_axis_tdata[63:32]),
        .i_full  (w_full),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_item  (w_push_item)
    );

    fr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_item  (w_head_item)
    );

    fr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_item     (w_head_item),
        .o_pop      (w_pop),
        .o_tvalid   (m_axis_tvalid),
        .i_tready   (m_axis_tready),
        .o_num      (w_num),
        .o_den      (w_den),
        .o_zero_den (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_den, w_num};

endmodule

@@ hw/rtl/fr_front.sv @@
// fr_front: input side, takes signs and magnitudes and classifies each word.
// Depends on fr_pkg; feeds fr_queue.
module fr_front
    import fr_pkg::*;
(
    input  logic               i_valid,
    input  logic [MAG_W-1:0]   i_num,
    input  logic [MAG_W-1:0]   i_den,
    input  logic               i_full,
    output logic               o_ready,
    output logic               o_push,
    output t_item              o_item
);

    logic [MAG_W-1:0] w_mag_n;
    logic [MAG_W-1:0] w_mag_d;

    assign w_mag_n = i_num[MAG_W-1] ? (~i_num + 32'd1) : i_num;
    assign w_mag_d = i_den[MAG_W-1] ? (~i_den + 32'd1) : i_den;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_item.neg   = i_num[MAG_W-1] ^ i_den[MAG_W-1];
        o_item.mag_n = w_mag_n;
        o_item.mag_d = w_mag_d;
        priority if (w_mag_d == '0) begin
            o_item.kind = KIND_ZERO_DEN;
        end else if (w_mag_n == '0) begin
            o_item.kind = KIND_ZERO_NUM;
        end else begin
            o_item.kind = KIND_NORMAL;
        end
    end

endmodule

@@ hw/rtl/fr_queue.sv @@
// fr_queue: small FIFO of classified words between front and back.
// Depends on fr_pkg.
module fr_queue
    import fr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_item   i_item,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_item   o_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int QCNT_W = $clog2(DEPTH + 1);

    t_item              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [QCNT_W-1:0]  r_count;

    logic [PTR_W-1:0]   n_wr;
    logic [PTR_W-1:0]   n_rd;

    assign o_full  = (r_count == QCNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd];

    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= n_wr;
            end
            if (i_pop) begin
                r_rd <= n_rd;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(DEPTH))
        else $error("queue count exceeds depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("pop from empty queue");

endmodule

@@ hw/rtl/fr_back.sv @@
// fr_back: binary GCD, two-lane restoring divide by the GCD, result register.
// Depends on fr_pkg; drains fr_queue.
module fr_back
    import fr_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_item              i_item,
    output logic               o_pop,
    output logic               o_tvalid,
    input  logic               i_tready,
    output logic [MAG_W-1:0]   o_num,
    output logic [DEN_W-1:0]   o_den,
    output logic               o_zero_den
);

    t_state             r_state;
    t_state             n_state;
    t_kind              r_kind;
    logic               r_neg;
    logic [MAG_W-1:0]   r_a;
    logic [MAG_W-1:0]   r_b;
    logic [CNT_W-1:0]   r_k;
    logic [MAG_W-1:0]   r_g;
    logic [MAG_W-1:0]   r_qn;
    logic [MAG_W-1:0]   r_qd;
    logic [DEN_W-1:0]   r_rn;
    logic [DEN_W-1:0]   r_rd;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_o_valid;
    logic [MAG_W-1:0]   r_o_num;
    logic [DEN_W-1:0]   r_o_den;
    logic               r_o_zd;

    logic               w_load;
    logic [MAG_W-1:0]   n_a;
    logic [MAG_W-1:0]   n_b;
    logic [CNT_W-1:0]   n_k;
    logic [MAG_W-1:0]   w_tn;
    logic [MAG_W-1:0]   w_td;
    logic               w_gen;
    logic               w_ged;
    logic [MAG_W-1:0]   w_sn;
    logic [MAG_W-1:0]   w_sd;
    logic [DEN_W-1:0]   n_rn;
    logic [DEN_W-1:0]   n_rd;
    logic [MAG_W-1:0]   w_signed_num;
    logic [MAG_W-1:0]   n_o_num;
    logic [DEN_W-1:0]   n_o_den;
    logic               n_o_zd;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = (i_item.kind == KIND_NORMAL) ? ST_GCD : ST_DONE;
                end
            end
            ST_GCD: begin
                if (r_a == r_b) begin
                    n_state = ST_SCALE;
                end
            end
            ST_SCALE: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_o_valid || i_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_pop  = 1'b0;
        w_load = 1'b0;
        unique case (r_state)
            ST_IDLE: o_pop  = !i_empty;
            ST_DONE: w_load = !r_o_valid || i_tready;
            default: begin
                o_pop  = 1'b0;
                w_load = 1'b0;
            end
        endcase
    end

    // binary GCD step
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_k = r_k;
        priority if (!r_a[0] && !r_b[0]) begin
            n_a = r_a >> 1;
            n_b = r_b >> 1;
            n_k = r_k + 1'b1;
        end else if (!r_a[0]) begin
            n_a = r_a >> 1;
        end else if (!r_b[0]) begin
            n_b = r_b >> 1;
        end else if (r_a > r_b) begin
            n_a = (r_a - r_b) >> 1;
        end else begin
            n_b = (r_b - r_a) >> 1;
        end
    end

    // restoring divide, one quotient bit per lane per cycle
    assign w_tn  = {r_rn, r_qn[MAG_W-1]};
    assign w_td  = {r_rd, r_qd[MAG_W-1]};
    assign w_gen = (w_tn >= r_g);
    assign w_ged = (w_td >= r_g);
    assign w_sn  = w_tn - r_g;
    assign w_sd  = w_td - r_g;
    assign n_rn  = w_gen ? w_sn[DEN_W-1:0] : w_tn[DEN_W-1:0];
    assign n_rd  = w_ged ? w_sd[DEN_W-1:0] : w_td[DEN_W-1:0];

    assign w_signed_num = r_neg ? (~r_qn + 32'd1) : r_qn;

    always_comb begin
        unique case (r_kind)
            KIND_NORMAL: begin
                n_o_num = w_signed_num;
                n_o_den = r_qd[DEN_W-1:0];
                n_o_zd  = 1'b0;
            end
            KIND_ZERO_DEN: begin
                n_o_num = '0;
                n_o_den = DEN_W'(1);
                n_o_zd  = 1'b1;
            end
            default: begin
                n_o_num = '0;
                n_o_den = DEN_W'(1);
                n_o_zd  = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_kind <= i_item.kind;
                    r_neg  <= i_item.neg;
                    r_a    <= i_item.mag_n;
                    r_b    <= i_item.mag_d;
                    r_qn   <= i_item.mag_n;
                    r_qd   <= i_item.mag_d;
                    r_k    <= '0;
                end
            end
            ST_GCD: begin
                if (r_a != r_b) begin
                    r_a <= n_a;
                    r_b <= n_b;
                    r_k <= n_k;
                end
            end
            ST_SCALE: begin
                r_g   <= r_a << r_k;
                r_rn  <= '0;
                r_rd  <= '0;
                r_cnt <= '0;
            end
            ST_DIV: begin
                r_rn  <= n_rn;
                r_rd  <= n_rd;
                r_qn  <= {r_qn[MAG_W-2:0], w_gen};
                r_qd  <= {r_qd[MAG_W-2:0], w_ged};
                r_cnt <= r_cnt + 1'b1;
            end
            default: begin
            end
        endcase
        if (w_load) begin
            r_o_num <= n_o_num;
            r_o_den <= n_o_den;
            r_o_zd  <= n_o_zd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_tvalid   = r_o_valid;
    assign o_num      = r_o_num;
    assign o_den      = r_o_den;
    assign o_zero_den = r_o_zd;

    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_GCD |-> (r_a != '0) && (r_b != '0))
        else $error("GCD operand reached zero");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> r_g != '0)
        else $error("divide by zero GCD");

    a_exact_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && (r_kind == KIND_NORMAL) |-> (r_rn == '0) && (r_rd == '0))
        else $error("GCD does not divide both magnitudes");

    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE) && w_load |=> (r_state == ST_IDLE) && o_tvalid)
        else $error("result not presented after completion");

endmodule

@@ tb/fraction_reducer_core_tb.sv @@
// fraction_reducer_core_tb: self-checking testbench for the fraction reducer core.
// Directed table plus random fractions, checked word by word against an in-bench predictor.
// Depends on fr_pkg and fraction_reducer_core.
module fraction_reducer_core_tb
    import fr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIR     = 25;
    localparam int NUM_RANDOM  = 1100;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 2000;
    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN       = 200;

    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MAX = 32'h8000_0001;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [MAG_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             zden;
    } t_reduced;

    typedef struct packed {
        logic [31:0] n;
        logic [31:0] d;
        logic        typed;
        t_reduced    res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    t_reduced    offer_res = '0;
    t_reduced    pending_fracs [$];
    t_stim_row   dir_rows [NUM_DIR];
    int          n_errors = 0;
    int          words_out = 0;
    int          stall_cycles = 0;
    int          tx_idle_pct = 29;
    int          rx_idle_pct = 55;
    bit          hold_done = 1'b0;

    fraction_reducer_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic t_reduced reduce_fraction(input logic [31:0] n_raw,
                                                 input logic [31:0] d_raw);
        t_reduced    r;
        logic        neg_n;
        logic        neg_d;
        logic [31:0] mag_n;
        logic [31:0] mag_d;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] rem;
        logic [31:0] q;
        neg_n = n_raw[31];
        neg_d = d_raw[31];
        mag_n = neg_n ? (~n_raw + 32'd1) : n_raw;
        mag_d = neg_d ? (~d_raw + 32'd1) : d_raw;
        r = '0;
        if (mag_d == 32'd0) begin
            r.den  = 31'd1;
            r.zden = 1'b1;
        end else if (mag_n == 32'd0) begin
            r.den = 31'd1;
        end else begin
            a = mag_n;
            b = mag_d;
            while (b != 32'd0) begin
                rem = a % b;
                a   = b;
                b   = rem;
            end
            q     = mag_n / a;
            r.num = (neg_n != neg_d) ? (~q + 32'd1) : q;
            q     = mag_d / a;
            r.den = q[DEN_W-1:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        n_errors++;
    endtask

    // one word out per handshake; random idle gaps, possibly none, before each offer
    task automatic send_word(input logic [31:0] n, input logic [31:0] d,
                             input t_reduced res);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {d, n};
        offer_res     <= res;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // monitor: expectation capture, result check, watchdog
    always @(posedge i_clk) begin
        t_reduced got;
        t_reduced want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready)
                pending_fracs.push_back(offer_res);
            if (m_axis_tvalid && m_axis_tready) begin
                got.num  = m_axis_tdata[31:0];
                got.den  = m_axis_tdata[62:32];
                got.zden = m_axis_tuser;
                words_out <= words_out + 1;
                if (pending_fracs.size() == 0) begin
                    report_mismatch($sformatf("unexpected word num=%h den=%h zden=%b",
                                              got.num, got.den, got.zden));
                end else begin
                    want = pending_fracs.pop_front();
                    if (got.num !== want.num)
                        report_mismatch($sformatf("numerator got %h want %h",
                                                  got.num, want.num));
                    if (got.den !== want.den)
                        report_mismatch($sformatf("denominator got %h want %h",
                                                  got.den, want.den));
                    if (got.zden !== want.zden)
                        report_mismatch($sformatf("zero_denominator got %b want %b",
                                                  got.zden, want.zden));
                end
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
                if (stall_cycles >= STALL_LIMIT) begin
                    $display("Watchdog expired with %0d words outstanding",
                             pending_fracs.size());
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
    end

    // receiver: random backpressure plus one long hold to fill the block
    initial begin
        forever begin
            @(posedge i_clk);
            if (!hold_done && words_out >= HOLD_AT) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    initial begin
        logic [31:0] n;
        logic [31:0] d;
        int          fac;
        int          v;
        t_reduced    r1;
        t_reduced    r0;
        t_reduced    rz;
        r1 = '{num: 32'd1, den: 31'd1, zden: 1'b0};
        r0 = '{num: 32'd0, den: 31'd1, zden: 1'b0};
        rz = '{num: 32'd0, den: 31'd1, zden: 1'b1};
        dir_rows = '{
            '{n: 32'd0,        d: 32'd0,          typed: 1'b1, res: rz},
            '{n: 32'd5,        d: 32'd0,          typed: 1'b1, res: rz},
            '{n: -32'sd7,      d: 32'd0,          typed: 1'b1, res: rz},
            '{n: NEG_MIN,      d: 32'd0,          typed: 1'b1, res: rz},
            '{n: 32'd0,        d: 32'd5,          typed: 1'b1, res: r0},
            '{n: 32'd0,        d: -32'sd5,        typed: 1'b1, res: r0},
            '{n: 32'd0,        d: NEG_MIN,        typed: 1'b1, res: r0},
            '{n: 32'd1,        d: 32'd1,          typed: 1'b1, res: r1},
            '{n: -32'sd1,      d: 32'd1,          typed: 1'b1,
              res: '{num: 32'hFFFF_FFFF, den: 31'd1, zden: 1'b0}},
            '{n: 32'd1,        d: -32'sd1,        typed: 1'b1,
              res: '{num: 32'hFFFF_FFFF, den: 31'd1, zden: 1'b0}},
            '{n: -32'sd1,      d: -32'sd1,        typed: 1'b1, res: r1},
            '{n: POS_MAX,      d: POS_MAX,        typed: 1'b1, res: r1},
            '{n: POS_MAX,      d: 32'd1,          typed: 1'b1,
              res: '{num: POS_MAX, den: 31'd1, zden: 1'b0}},
            '{n: 32'd1,        d: POS_MAX,        typed: 1'b1,
              res: '{num: 32'd1, den: 31'h7FFF_FFFF, zden: 1'b0}},
            '{n: NEG_MAX,      d: POS_MAX,        typed: 1'b1,
              res: '{num: 32'hFFFF_FFFF, den: 31'd1, zden: 1'b0}},
            '{n: NEG_MIN,      d: NEG_MIN,        typed: 1'b1, res: r1},
            '{n: 32'd6,        d: 32'd4,          typed: 1'b0, res: r0},
            '{n: -32'sd6,      d: 32'd4,          typed: 1'b0, res: r0},
            '{n: 32'd12,       d: -32'sd18,       typed: 1'b0, res: r0},
            '{n: NEG_MIN,      d: 32'd1,          typed: 1'b0, res: r0},
            '{n: 32'd1,        d: NEG_MIN,        typed: 1'b0, res: r0},
            '{n: NEG_MIN,      d: 32'd2,          typed: 1'b0, res: r0},
            '{n: POS_MAX,      d: NEG_MIN,        typed: 1'b0, res: r0},
            '{n: 32'h5555_5555, d: 32'hAAAA_AAAA, typed: 1'b0, res: r0},
            '{n: 32'd1836311903, d: 32'd1134903170, typed: 1'b0, res: r0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].n, dir_rows[i].d,
                      dir_rows[i].typed ? dir_rows[i].res
                                        : reduce_fraction(dir_rows[i].n, dir_rows[i].d));
        end

        for (int k = 0; k < NUM_RANDOM; k++) begin
            if (k == NUM_RANDOM / 3) begin
                tx_idle_pct = 55;
                rx_idle_pct = 29;
            end else if (k == 2 * NUM_RANDOM / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    n = $urandom();
                    d = $urandom();
                end
                3, 4, 5: begin
                    // shared factor so the gcd is nontrivial unless the factor is 1 or n is zero
                    fac = $urandom_range(1, 65535);
                    v   = fac * $urandom_range(0, 32767);
                    n   = $urandom_range(0, 1) ? -v : v;
                    v   = fac * $urandom_range(1, 32767);
                    d   = $urandom_range(0, 1) ? -v : v;
                end
                6: begin
                    v = $urandom_range(0, 40);
                    n = v - 20;
                    v = $urandom_range(0, 40);
                    d = v - 20;
                end
                7: begin
                    n = $urandom();
                    d = $urandom();
                    if ($urandom_range(0, 1))
                        d = 32'd0;
                    else
                        n = 32'd0;
                end
                8: begin
                    case ($urandom_range(0, 4))
                        0: n = POS_MAX;
                        1: n = NEG_MAX;
                        2: n = NEG_MIN;
                        3: n = 32'd1;
                        default: n = 32'hFFFF_FFFF;
                    endcase
                    case ($urandom_range(0, 4))
                        0: d = POS_MAX;
                        1: d = NEG_MAX;
                        2: d = NEG_MIN;
                        3: d = 32'd1;
                        default: d = $urandom();
                    endcase
                end
                default: begin
                    n = 32'd1 << $urandom_range(0, 31);
                    d = (32'd1 << $urandom_range(0, 31)) * $urandom_range(1, 7);
                    if ($urandom_range(0, 1))
                        n = -n;
                    if ($urandom_range(0, 1))
                        d = -d;
                end
            endcase
            send_word(n, d, reduce_fraction(n, d));
        end
        s_axis_tvalid <= 1'b0;

        while (pending_fracs.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (n_errors == 0 && pending_fracs.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
